// ===== sv/bgdw_pkg.sv =====
// Shared package of the bounded graph DFS walker: field widths, parameter
// defaults and the command/status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package bgdw_pkg;

    localparam int KMER_BITS_DEF       = 64;
    localparam int STACK_ENTRIES_DEF   = 4096;
    localparam int VISITED_ENTRIES_DEF = 1024;
    localparam int MAX_NEIGHBOURS_DEF  = 4;

    localparam int KMER_W  = 64;
    localparam int DEPTH_W = 16;
    localparam int COUNT_W = 3;
    localparam int VLIM_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PORT_NB    = 4;

    localparam int S_TDATA_W = 584;
    localparam int M_TDATA_W = 96;

    localparam logic OP_START     = 1'b0;
    localparam logic OP_ADJACENCY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOLLOW_CHILDREN = 2'd0,
        REG_FOLLOW_PARENTS  = 2'd1,
        REG_DEPTH_LIMIT     = 2'd2,
        REG_VERTEX_LIMIT    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic start;
        logic pop_rd;
        logic pop_use;
        logic scan_start;
        logic scan_run;
        logic mark;
        logic slot_skip;
        logic nb_push;
        logic out_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic opcode;
        logic enabled;
        logic sp_nz;
        logic scan_done;
        logic slot_end;
        logic slot_ok;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/bgdw_datapath.sv =====
// Datapath of the DFS walker: stack and visited memories, item latch,
// visited-set scan unit, counters, configuration and the result register.
// Depends on bgdw_pkg.
`timescale 1ns / 1ps

module bgdw_datapath #(
    parameter int KMER_BITS       = bgdw_pkg::KMER_BITS_DEF,
    parameter int STACK_ENTRIES   = bgdw_pkg::STACK_ENTRIES_DEF,
    parameter int VISITED_ENTRIES = bgdw_pkg::VISITED_ENTRIES_DEF,
    parameter int MAX_NEIGHBOURS  = bgdw_pkg::MAX_NEIGHBOURS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  bgdw_pkg::cmd_t                         cmd,
    output bgdw_pkg::sts_t                         sts,
    input  logic                                   cfg_wr_en,
    input  logic [bgdw_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bgdw_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_opcode,
    input  logic [bgdw_pkg::KMER_W-1:0]            in_seed,
    input  logic [bgdw_pkg::COUNT_W-1:0]           in_child_count,
    input  logic [bgdw_pkg::PORT_NB-1:0][bgdw_pkg::KMER_W-1:0] in_children,
    input  logic [bgdw_pkg::COUNT_W-1:0]           in_parent_count,
    input  logic [bgdw_pkg::PORT_NB-1:0][bgdw_pkg::KMER_W-1:0] in_parents,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [bgdw_pkg::KMER_W-1:0]            out_fetch_vertex,
    output logic [bgdw_pkg::DEPTH_W-1:0]           out_fetch_depth,
    output logic                                   out_searching,
    output logic                                   out_finished,
    output logic                                   out_depth_reached,
    output logic [bgdw_pkg::VLIM_W-1:0]            out_visited_total,
    output logic                                   out_overflowed
);

    localparam int SA_W   = $clog2(STACK_ENTRIES);
    localparam int SP_W   = $clog2(STACK_ENTRIES + 1);
    localparam int VA_W   = $clog2(VISITED_ENTRIES);
    localparam int VC_W   = $clog2(VISITED_ENTRIES + 1);
    localparam int CMP_W  = (VC_W > bgdw_pkg::VLIM_W) ? VC_W : bgdw_pkg::VLIM_W;
    localparam int NSLOT  = 2 * MAX_NEIGHBOURS;
    localparam int SLOT_W = $clog2(NSLOT + 1);
    localparam int SI_W   = $clog2(NSLOT);
    localparam int DW     = bgdw_pkg::DEPTH_W;

    // memories
    logic [KMER_BITS-1:0] stk_v_mem [STACK_ENTRIES];
    logic [DW-1:0]        stk_d_mem [STACK_ENTRIES];
    logic [KMER_BITS-1:0] vis_mem   [VISITED_ENTRIES];
    logic [KMER_BITS-1:0] stk_v_rd_reg;
    logic [DW-1:0]        stk_d_rd_reg;
    logic [KMER_BITS-1:0] vis_rd_reg;

    // configuration
    logic          fc_reg, fp_reg;
    logic [DW-1:0] dlimit_reg;
    logic [bgdw_pkg::VLIM_W-1:0] vlimit_reg;

    // state
    logic [SP_W-1:0] sp_reg;
    logic [VC_W-1:0] vc_reg;
    logic [DW-1:0]   deep_reg;
    logic            ovf_reg;

    // latched item
    logic                 op_reg;
    logic [KMER_BITS-1:0] seed_reg;
    logic [KMER_BITS-1:0] nb_reg [NSLOT];
    logic [bgdw_pkg::COUNT_W-1:0] ccnt_reg, pcnt_reg;

    // walk state
    logic [DW-1:0]        cur_d_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [KMER_BITS-1:0] key_reg;
    logic [VC_W-1:0]      idx_reg;
    logic                 cmp_valid_reg;
    logic                 hit_reg;

    logic [SP_W-1:0] sp_m1;
    logic            scan_rd_en;
    logic            hit_now, scan_hit;
    logic            slot_dir;
    logic [SLOT_W-1:0] slot_pos;
    logic            dir_en, pos_ok, depth_ok, vlim_ok;
    logic [DW:0]     next_depth;
    logic            out_valid_reg;

    assign sp_m1 = sp_reg - SP_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg     <= 1'b1;
            fp_reg     <= 1'b1;
            dlimit_reg <= '0;
            vlimit_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (bgdw_pkg::cfg_reg_t'(cfg_index))
                bgdw_pkg::REG_FOLLOW_CHILDREN: fc_reg <= cfg_data[0];
                bgdw_pkg::REG_FOLLOW_PARENTS:  fp_reg <= cfg_data[0];
                bgdw_pkg::REG_DEPTH_LIMIT:     dlimit_reg <= cfg_data[DW-1:0];
                bgdw_pkg::REG_VERTEX_LIMIT:    vlimit_reg <= cfg_data[bgdw_pkg::VLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // latch the accepted request; counts saturate at the neighbor limit
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_opcode;
            seed_reg <= in_seed[KMER_BITS-1:0];
            ccnt_reg <= (in_child_count > 3'(MAX_NEIGHBOURS)) ? 3'(MAX_NEIGHBOURS)
                                                              : in_child_count;
            pcnt_reg <= (in_parent_count > 3'(MAX_NEIGHBOURS)) ? 3'(MAX_NEIGHBOURS)
                                                               : in_parent_count;
            for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
                nb_reg[i]                  <= in_children[i][KMER_BITS-1:0];
                nb_reg[MAX_NEIGHBOURS + i] <= in_parents[i][KMER_BITS-1:0];
            end
        end
    end

    // stack memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            stk_v_mem[0] <= seed_reg;
            stk_d_mem[0] <= '0;
        end else if (cmd.nb_push && !scan_hit && sp_reg < SP_W'(STACK_ENTRIES)) begin
            stk_v_mem[sp_reg[SA_W-1:0]] <= key_reg;
            stk_d_mem[sp_reg[SA_W-1:0]] <= next_depth[DW-1:0];
        end
        if (cmd.pop_rd || cmd.out_rd) begin
            stk_v_rd_reg <= stk_v_mem[sp_m1[SA_W-1:0]];
            stk_d_rd_reg <= stk_d_mem[sp_m1[SA_W-1:0]];
        end
    end

    // visited memory
    always_ff @(posedge aclk) begin
        if (cmd.mark && !scan_hit && vc_reg < VC_W'(VISITED_ENTRIES))
            vis_mem[vc_reg[VA_W-1:0]] <= key_reg;
        if (scan_rd_en)
            vis_rd_reg <= vis_mem[idx_reg[VA_W-1:0]];
    end

    // scan unit: one entry read per cycle, compared in the cycle after the read
    assign scan_rd_en = cmd.scan_run && (idx_reg < vc_reg) && !hit_reg;
    assign hit_now    = cmp_valid_reg && (vis_rd_reg == key_reg);
    assign scan_hit   = hit_reg || hit_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            idx_reg       <= '0;
        end else if (cmd.pop_use || cmd.scan_start) begin
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cmp_valid_reg <= scan_rd_en;
            if (hit_now) hit_reg <= 1'b1;
            if (scan_rd_en) idx_reg <= idx_reg + VC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop_use) key_reg <= stk_v_rd_reg;
        else if (cmd.scan_start) key_reg <= nb_reg[slot_reg[SI_W-1:0]];
        if (cmd.pop_use) cur_d_reg <= stk_d_rd_reg;
    end

    // neighbor slot qualification
    assign slot_dir   = slot_reg >= SLOT_W'(MAX_NEIGHBOURS);
    assign slot_pos   = slot_dir ? slot_reg - SLOT_W'(MAX_NEIGHBOURS) : slot_reg;
    assign dir_en     = slot_dir ? fp_reg : fc_reg;
    assign pos_ok     = 4'(slot_pos) < {1'b0, (slot_dir ? pcnt_reg : ccnt_reg)};
    assign next_depth = {1'b0, cur_d_reg} + (DW+1)'(1);
    assign depth_ok   = next_depth <= {1'b0, dlimit_reg};
    assign vlim_ok    = CMP_W'(vc_reg) < CMP_W'(vlimit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (cmd.mark) begin
            slot_reg <= '0;
        end else if (cmd.slot_skip || cmd.nb_push) begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
    end

    // walk counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg   <= '0;
            vc_reg   <= '0;
            deep_reg <= '0;
            ovf_reg  <= 1'b0;
        end else if (cmd.start) begin
            sp_reg   <= SP_W'(1);
            vc_reg   <= '0;
            deep_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            if (cmd.pop_use) begin
                sp_reg <= sp_m1;
                if (stk_d_rd_reg > deep_reg) deep_reg <= stk_d_rd_reg;
            end
            if (cmd.mark && !scan_hit) begin
                if (vc_reg < VC_W'(VISITED_ENTRIES)) vc_reg <= vc_reg + VC_W'(1);
                else ovf_reg <= 1'b1;
            end
            if (cmd.nb_push && !scan_hit) begin
                if (sp_reg < SP_W'(STACK_ENTRIES)) sp_reg <= sp_reg + SP_W'(1);
                else ovf_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_fetch_vertex  <= (sp_reg != '0) ? bgdw_pkg::KMER_W'(stk_v_rd_reg) : '0;
            out_fetch_depth   <= (sp_reg != '0) ? stk_d_rd_reg : '0;
            out_searching     <= (sp_reg != '0) && (fc_reg || fp_reg);
            out_finished      <= (sp_reg == '0);
            out_depth_reached <= deep_reg >= dlimit_reg;
            out_visited_total <= bgdw_pkg::VLIM_W'(vc_reg);
            out_overflowed    <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;

    assign sts.opcode    = op_reg;
    assign sts.enabled   = fc_reg || fp_reg;
    assign sts.sp_nz     = (sp_reg != '0);
    assign sts.scan_done = hit_now || hit_reg || ((idx_reg >= vc_reg) && !cmp_valid_reg);
    assign sts.slot_end  = (slot_reg == SLOT_W'(NSLOT));
    assign sts.slot_ok   = dir_en && pos_ok && depth_ok && vlim_ok;
    assign sts.out_free  = !out_valid_reg || out_ready;

    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STACK_ENTRIES))
        else $error("stack pointer beyond stack depth");
    a_vc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vc_reg <= VC_W'(VISITED_ENTRIES))
        else $error("visited count beyond store depth");
    a_start_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (!ovf_reg && sp_reg == SP_W'(1) && vc_reg == '0))
        else $error("start did not reset the walk");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.nb_push && !scan_hit && sp_reg == SP_W'(STACK_ENTRIES)) |=> ovf_reg)
        else $error("dropped push did not flag overflow");

endmodule

// ===== sv/bgdw_ctrl.sv =====
// Controller of the DFS walker: sequences pop, visit marking, neighbor
// scans and pushes, and result loading. Depends on bgdw_pkg.
`timescale 1ns / 1ps

module bgdw_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  bgdw_pkg::sts_t sts,
    output bgdw_pkg::cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_DECODE    = 10'b0000000010,
        ST_START     = 10'b0000000100,
        ST_POP_RD    = 10'b0000001000,
        ST_POP_USE   = 10'b0000010000,
        ST_MARK_SCAN = 10'b0000100000,
        ST_NB_CHECK  = 10'b0001000000,
        ST_NB_SCAN   = 10'b0010000000,
        ST_OUT_RD    = 10'b0100000000,
        ST_OUT_LOAD  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.opcode == bgdw_pkg::OP_START) state_next = ST_START;
                else if (sts.enabled && sts.sp_nz)    state_next = ST_POP_RD;
                else                                  state_next = ST_OUT_RD;
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = ST_OUT_RD;
            end
            ST_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POP_USE;
            end
            ST_POP_USE: begin
                cmd.pop_use = 1'b1;
                state_next  = ST_MARK_SCAN;
            end
            ST_MARK_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    cmd.mark   = 1'b1;
                    state_next = ST_NB_CHECK;
                end
            end
            ST_NB_CHECK: begin
                if (sts.slot_end) begin
                    state_next = ST_OUT_RD;
                end else if (sts.slot_ok) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_NB_SCAN;
                end else begin
                    cmd.slot_skip = 1'b1;
                end
            end
            ST_NB_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    cmd.nb_push = 1'b1;
                    state_next  = ST_NB_CHECK;
                end
            end
            ST_OUT_RD: begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted request did not enter decode");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a waiting result");
    a_scan_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.nb_push |=> (state_reg == ST_NB_CHECK))
        else $error("push not followed by slot check");

endmodule

// ===== sv/bounded_graph_dfs_walker_unit.sv =====
// Top level of the bounded graph DFS walker: stream ports, field packing,
// controller and datapath. Depends on bgdw_pkg, bgdw_ctrl, bgdw_datapath.
`timescale 1ns / 1ps

// Usage:
// Send one request per item on the s_ channel. s_tuser carries the opcode:
// start (seed a new walk) or adjacency (neighbors of the vertex that the
// last result named in fetch_vertex). Every request returns exactly one
// result on the m_ channel describing the walk state after the update.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// while no request is in flight.
// Steps: a start passes decode and the start state. An adjacency request
// passes decode, pop read and pop use, one visited-set scan for the popped
// vertex and, for each qualifying neighbor, one slot check and one scan;
// a scan reads the visited memory one entry per cycle and ends at the end
// of the set or on an early hit. Neighbor slots that do not qualify are
// skipped in the slot check. The next request is taken in the cycle after
// the result is loaded; one request is worked at a time and the
// visited-memory scan port sets the rate.
// Reset (aresetn low, synchronous) empties the stack and visited set,
// clears overflow and restores register defaults; memories are not cleared.
// A stalled receiver holds the result in the output register; the block
// accepts one more request and parks its result until the first is taken.
module bounded_graph_dfs_walker_unit #(
    parameter int KMER_BITS       = bgdw_pkg::KMER_BITS_DEF,
    parameter int STACK_ENTRIES   = bgdw_pkg::STACK_ENTRIES_DEF,
    parameter int VISITED_ENTRIES = bgdw_pkg::VISITED_ENTRIES_DEF,
    parameter int MAX_NEIGHBOURS  = bgdw_pkg::MAX_NEIGHBOURS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [bgdw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bgdw_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // seed_vertex, child_count, child_a..child_d, parent_count,
    // parent_a..parent_d, two zero bits
    input  logic [bgdw_pkg::S_TDATA_W-1:0]        s_tdata,
    // opcode
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // fetch_vertex, fetch_depth, searching, finished, depth_reached,
    // visited_total, overflowed, one zero bit
    output logic [bgdw_pkg::M_TDATA_W-1:0]        m_tdata
);

    bgdw_pkg::cmd_t cmd;
    bgdw_pkg::sts_t sts;

    logic [bgdw_pkg::PORT_NB-1:0][bgdw_pkg::KMER_W-1:0] children, parents;
    logic [bgdw_pkg::KMER_W-1:0]  fetch_vertex;
    logic [bgdw_pkg::DEPTH_W-1:0] fetch_depth;
    logic                         searching, finished, depth_reached, overflowed;
    logic [bgdw_pkg::VLIM_W-1:0]  visited_total;

    // unpack the neighbor lists from their fixed slots
    assign children[0] = s_tdata[130:67];
    assign children[1] = s_tdata[194:131];
    assign children[2] = s_tdata[258:195];
    assign children[3] = s_tdata[322:259];
    assign parents[0]  = s_tdata[389:326];
    assign parents[1]  = s_tdata[453:390];
    assign parents[2]  = s_tdata[517:454];
    assign parents[3]  = s_tdata[581:518];

    bgdw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bgdw_datapath #(
        .KMER_BITS       (KMER_BITS),
        .STACK_ENTRIES   (STACK_ENTRIES),
        .VISITED_ENTRIES (VISITED_ENTRIES),
        .MAX_NEIGHBOURS  (MAX_NEIGHBOURS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_opcode         (s_tuser),
        .in_seed           (s_tdata[63:0]),
        .in_child_count    (s_tdata[66:64]),
        .in_children       (children),
        .in_parent_count   (s_tdata[325:323]),
        .in_parents        (parents),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_fetch_vertex  (fetch_vertex),
        .out_fetch_depth   (fetch_depth),
        .out_searching     (searching),
        .out_finished      (finished),
        .out_depth_reached (depth_reached),
        .out_visited_total (visited_total),
        .out_overflowed    (overflowed)
    );

    // pack the result fields, lowest field first
    assign m_tdata = {1'b0, overflowed, visited_total, depth_reached, finished,
                      searching, fetch_depth, fetch_vertex};

endmodule
